// File: hdl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Types, codes and constants shared by the session table modules.
// ----------------------------------------------------------------------------
package mst_pkg;

   localparam int unsigned SLOTS_DEFAULT    = 64;
   localparam int unsigned CHANNELS_DEFAULT = 8;
   localparam int unsigned MAX_SWEEP        = 64;

   localparam logic [7:0]  EP_BEGIN    = 8'h00;
   localparam logic [7:0]  EP_PING     = 8'hFE;
   localparam logic [7:0]  EP_END      = 8'hFF;
   localparam logic [15:0] HDR_LEN     = 16'd4;
   localparam logic [15:0] TIMEOUT_RST = 16'd30000;

   localparam logic [2:0] OP_FRAME  = 3'd0;
   localparam logic [2:0] OP_SWEEP  = 3'd1;
   localparam logic [2:0] OP_SEND   = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_UNLOCK = 3'd4;

   localparam logic [0:0] CSR_TIMEOUT  = 1'd0;
   localparam logic [0:0] CSR_PASSWORD = 1'd1;

   localparam logic [4:0] ST_FORWARD   = 5'd0;
   localparam logic [4:0] ST_BEGUN     = 5'd1;
   localparam logic [4:0] ST_PING      = 5'd2;
   localparam logic [4:0] ST_ENDED     = 5'd3;
   localparam logic [4:0] ST_QUERY     = 5'd4;
   localparam logic [4:0] ST_SHORT     = 5'd5;
   localparam logic [4:0] ST_VERSION   = 5'd6;
   localparam logic [4:0] ST_BADSID    = 5'd7;
   localparam logic [4:0] ST_FULL      = 5'd8;
   localparam logic [4:0] ST_NOTFOUND  = 5'd9;
   localparam logic [4:0] ST_CHANMIS   = 5'd10;
   localparam logic [4:0] ST_BROKEN    = 5'd11;
   localparam logic [4:0] ST_TOOLARGE  = 5'd12;
   localparam logic [4:0] ST_SENT      = 5'd13;
   localparam logic [4:0] ST_SENDFAIL  = 5'd14;
   localparam logic [4:0] ST_SWEPT     = 5'd15;
   localparam logic [4:0] ST_SWEEPNONE = 5'd16;
   localparam logic [4:0] ST_UNLOCKED  = 5'd17;
   localparam logic [4:0] ST_UNLOCKREJ = 5'd18;
   localparam logic [4:0] ST_STATE     = 5'd19;

   typedef struct packed {
      logic        active;
      logic [15:0] id;
      logic [3:0]  channel;
      logic [15:0] mtu;
      logic [31:0] last_time;
      logic        locked;
      logic        broken;
   } slot_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  status;
      logic [15:0] session;
      logic        reply_code;
      logic [15:0] forward_len;
      logic        run_cleanup;
      logic        locked;
      logic [15:0] mtu;
      logic        last;
   } result_type;

endpackage

// File: hdl/mst_slot_ram.sv
// ----------------------------------------------------------------------------
// mst_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mst_slot_ram #(
   parameter int unsigned SLOTS = 64,
   parameter int unsigned AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  mst_pkg::slot_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output mst_pkg::slot_type rd_data
);
   import mst_pkg::*;

   slot_type mem [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/message_session_table.sv
// ----------------------------------------------------------------------------
// message_session_table
// Session table for a message dispatcher, kept in one slot memory.
// ----------------------------------------------------------------------------
// Usage: pulse start with the req_ fields while busy is low. Results appear
// one per cycle-strobe on rsp_valid with the rsp_ fields; rsp_last marks the
// final result of an item. The receiver cannot stall: every result shows for
// exactly one cycle. csr_ writes set idle_timeout (index 0) and password_set
// (index 1) and must happen only while busy is low.
// After reset a clearing pass writes every slot empty, one slot a cycle, and
// busy stays high until the pass has reached the last slot.
// Each item walks the slot memory one slot a cycle through its single read
// port, then takes one action and write-back step; its final result shows
// in the done state that follows. A new item is taken only once busy is low
// again. A sweep reads every slot and clears the expired ones, up to
// MAX_SWEEP, in one walk, giving each cleared id as it goes. Unused op
// codes give no result and go from the walk straight to the done state.
// ----------------------------------------------------------------------------
module message_session_table #(
   parameter int unsigned SESSION_SLOTS = mst_pkg::SLOTS_DEFAULT,
   parameter int unsigned CHANNEL_COUNT = mst_pkg::CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_frame_len,
   input  logic [7:0]  req_frame_version,
   input  logic [15:0] req_session_id,
   input  logic [7:0]  req_endpoint_id,
   input  logic [2:0]  req_channel,
   input  logic [15:0] req_channel_mtu,
   input  logic [31:0] req_now_ms,
   input  logic        req_endpoint_known,
   input  logic [15:0] req_payload_len,
   input  logic        req_send_ok,
   input  logic        req_password_match,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data,
   output logic        rsp_valid,
   output logic [4:0]  rsp_status,
   output logic [15:0] rsp_result_session,
   output logic        rsp_reply_code,
   output logic [15:0] rsp_forward_len,
   output logic        rsp_run_cleanup,
   output logic        rsp_session_locked,
   output logic [15:0] rsp_session_mtu,
   output logic        rsp_last
);
   import mst_pkg::*;

   localparam int unsigned AW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam logic [AW:0] LAST_SLOT = (AW+1)'(SESSION_SLOTS - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_WALK  = 5'b00100,
      S_ACT   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [AW:0] rd_ptr_ff, rd_ptr_in;      // next address to read
   logic [AW:0] chk_ptr_ff, chk_ptr_in;    // address whose data is on rd_data
   logic        chk_valid_ff, chk_valid_in;
   logic        found_ff, found_in;        // id match seen
   logic        free_ff, free_in;          // free slot seen
   logic [AW-1:0] hit_ff, hit_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   slot_type    hit_slot_ff, hit_slot_in;
   logic [6:0]  swept_ff, swept_in;
   logic [15:0] timeout_ff;
   logic        pw_ff;
   logic [15:0] next_id_ff, next_id_in;

   logic [2:0]  op_ff;
   logic [15:0] len_ff, sid_ff, cmtu_ff, plen_ff;
   logic [7:0]  ver_ff, eid_ff;
   logic [2:0]  ch_ff;
   logic [31:0] now_ff;
   logic        known_ff, ok_ff, pwm_ff;

   result_type  res_ff, res_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr;
   slot_type    wr_data;
   slot_type    rd_data;
   logic        accept;
   logic        expired;
   logic [15:0] tmp_plen;
   logic        ch_bad;

   mst_slot_ram #(.SLOTS(SESSION_SLOTS), .AW(AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_ptr_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign expired = rd_data.broken ||
                    ((now_ff - rd_data.last_time) >= {16'd0, timeout_ff});
   assign ch_bad = ({2'b0, ch_ff} >= 5'(CHANNEL_COUNT));
   assign tmp_plen = plen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         pw_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIMEOUT:  timeout_ff <= csr_data;
            CSR_PASSWORD: pw_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         len_ff   <= req_frame_len;
         ver_ff   <= req_frame_version;
         sid_ff   <= req_session_id;
         eid_ff   <= req_endpoint_id;
         ch_ff    <= req_channel;
         cmtu_ff  <= req_channel_mtu;
         now_ff   <= req_now_ms;
         known_ff <= req_endpoint_known;
         plen_ff  <= req_payload_len;
         ok_ff    <= req_send_ok;
         pwm_ff   <= req_password_match;
      end
   end

   function automatic result_type mk(input logic [4:0] st, input logic [15:0] s);
      result_type r;
      r = '0;
      r.valid   = 1'b1;
      r.status  = st;
      r.session = s;
      r.last    = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_ptr_in   = rd_ptr_ff;
      chk_valid_in = 1'b0;
      found_in     = found_ff;
      free_in      = free_ff;
      hit_in       = hit_ff;
      free_idx_in  = free_idx_ff;
      hit_slot_in  = hit_slot_ff;
      swept_in     = swept_ff;
      next_id_in   = next_id_ff;
      res_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = rd_ptr_ff[AW-1:0];
      wr_data      = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en     = 1'b1;
            rd_ptr_in = rd_ptr_ff + 1'b1;
            if (rd_ptr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_ptr_in = '0;
            found_in  = 1'b0;
            free_in   = 1'b0;
            swept_in  = '0;
            if (accept) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (rd_ptr_ff <= LAST_SLOT) begin
               rd_ptr_in    = rd_ptr_ff + 1'b1;
               chk_valid_in = 1'b1;
            end
            if (chk_valid_ff) begin
               if (op_ff == OP_SWEEP) begin
                  if (rd_data.active && expired && (swept_ff < 7'(MAX_SWEEP))) begin
                     wr_en   = 1'b1;
                     wr_addr = chk_ptr_ff[AW-1:0];
                     res_in  = mk(ST_SWEPT, rd_data.id);
                     res_in.run_cleanup = 1'b1;
                     res_in.last = (chk_ptr_ff == LAST_SLOT);
                     swept_in = swept_ff + 1'b1;
                  end
               end else begin
                  if (!rd_data.active && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_ptr_ff[AW-1:0];
                  end
                  if (rd_data.id == sid_ff && !found_ff) begin
                     found_in    = 1'b1;
                     hit_in      = chk_ptr_ff[AW-1:0];
                     hit_slot_in = rd_data;
                  end
               end
            end
            if (!chk_valid_in && !(rd_ptr_ff <= LAST_SLOT)) begin
               state_in = S_ACT;
            end
            if (op_ff > OP_UNLOCK) begin
               state_in = S_DONE;
            end
         end
         S_ACT: begin
            state_in = S_DONE;
            wr_addr  = hit_ff;
            wr_data  = hit_slot_ff;
            case (op_ff)
               OP_SWEEP: begin
                  if (swept_ff == '0) begin
                     res_in = mk(ST_SWEEPNONE, 16'd0);
                  end
               end
               OP_FRAME: begin
                  if (len_ff < HDR_LEN) begin
                     res_in = mk(ST_SHORT, sid_ff);
                  end else if (ver_ff != 8'd1) begin
                     res_in = mk(ST_VERSION, sid_ff);
                  end else if (eid_ff == EP_BEGIN) begin
                     if (sid_ff != 16'd0) begin
                        res_in = mk(ST_BADSID, sid_ff);
                     end else if (ch_bad) begin
                        res_in = mk(ST_CHANMIS, sid_ff);
                     end else if (!free_ff) begin
                        res_in = mk(ST_FULL, sid_ff);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_ff;
                        wr_data.active    = 1'b1;
                        wr_data.id        = next_id_ff;
                        wr_data.channel   = {1'b0, ch_ff};
                        wr_data.mtu       = cmtu_ff;
                        wr_data.last_time = now_ff;
                        wr_data.locked    = pw_ff;
                        wr_data.broken    = 1'b0;
                        next_id_in = next_id_ff + 16'd1;
                        res_in = mk(ST_BEGUN, next_id_ff);
                     end
                  end else if (!found_ff || !hit_slot_ff.active) begin
                     res_in = mk(ST_NOTFOUND, sid_ff);
                  end else if (hit_slot_ff.channel != {1'b0, ch_ff}) begin
                     res_in = mk(ST_CHANMIS, sid_ff);
                  end else if (hit_slot_ff.broken) begin
                     res_in = mk(ST_BROKEN, sid_ff);
                  end else if (eid_ff == EP_END) begin
                     wr_en   = 1'b1;
                     wr_data = '0;
                     res_in  = mk(ST_ENDED, sid_ff);
                     res_in.run_cleanup = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     wr_data.last_time = now_ff;
                     if (eid_ff == EP_PING) begin
                        res_in = mk(ST_PING, sid_ff);
                     end else if (len_ff == HDR_LEN) begin
                        res_in = mk(ST_QUERY, sid_ff);
                        res_in.reply_code = !known_ff;
                     end else begin
                        res_in = mk(ST_FORWARD, sid_ff);
                        res_in.forward_len = len_ff - HDR_LEN;
                     end
                  end
               end
               OP_SEND: begin
                  if (!found_ff || !hit_slot_ff.active) begin
                     res_in = mk(ST_NOTFOUND, sid_ff);
                  end else if (hit_slot_ff.broken) begin
                     res_in = mk(ST_BROKEN, sid_ff);
                  end else if (({1'b0, tmp_plen} + {1'b0, HDR_LEN}) >
                               {1'b0, hit_slot_ff.mtu}) begin
                     res_in = mk(ST_TOOLARGE, sid_ff);
                  end else if (ok_ff) begin
                     wr_en = 1'b1;
                     wr_data.last_time = now_ff;
                     res_in = mk(ST_SENT, sid_ff);
                  end else begin
                     wr_en = 1'b1;
                     wr_data.broken = 1'b1;
                     res_in = mk(ST_SENDFAIL, sid_ff);
                  end
               end
               OP_QUERY: begin
                  res_in = mk(ST_STATE, sid_ff);
                  if (found_ff && hit_slot_ff.active) begin
                     res_in.locked = hit_slot_ff.locked;
                     res_in.mtu    = hit_slot_ff.mtu;
                  end
               end
               OP_UNLOCK: begin
                  if (found_ff && hit_slot_ff.active && hit_slot_ff.locked && pwm_ff) begin
                     wr_en = 1'b1;
                     wr_data.locked = 1'b0;
                     res_in = mk(ST_UNLOCKED, sid_ff);
                  end else begin
                     res_in = mk(ST_UNLOCKREJ, sid_ff);
                  end
               end
               default: ;
            endcase
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // last swept result is held back and gets its flag in the action cycle
   result_type pend_ff, pend_in;
   logic       hold_out;

   always_comb begin
      pend_in  = pend_ff;
      hold_out = 1'b0;
      if (res_in.valid && res_in.status == ST_SWEPT) begin
         hold_out = 1'b1;
         pend_in  = res_in;
      end
      if (state_ff == S_ACT && op_ff == OP_SWEEP) begin
         pend_in.valid = 1'b0;
      end
   end

   result_type out_ff, out_in;

   always_comb begin
      out_in = res_in;
      if (hold_out || (state_ff == S_ACT && op_ff == OP_SWEEP && swept_ff != '0)) begin
         out_in = '0;
         if (pend_ff.valid) begin
            out_in = pend_ff;
            out_in.last = (state_ff == S_ACT);
         end
      end
      if (state_ff == S_ACT && op_ff == OP_SWEEP && swept_ff == '0) begin
         out_in = res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rd_ptr_ff    <= '0;
         chk_ptr_ff   <= '0;
         chk_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         swept_ff     <= '0;
         next_id_ff   <= 16'd1;
         out_ff       <= '0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         chk_ptr_ff   <= chk_ptr_in;
         chk_valid_ff <= chk_valid_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         swept_ff     <= swept_in;
         next_id_ff   <= next_id_in;
         out_ff       <= out_in;
         pend_ff      <= (state_ff == S_IDLE) ? '0 : pend_in;
      end
      hit_ff      <= hit_in;
      free_idx_ff <= free_idx_in;
      hit_slot_ff <= hit_slot_in;
   end

   assign rsp_valid          = out_ff.valid;
   assign rsp_status         = out_ff.status;
   assign rsp_result_session = out_ff.session;
   assign rsp_reply_code     = out_ff.reply_code;
   assign rsp_forward_len    = out_ff.forward_len;
   assign rsp_run_cleanup    = out_ff.run_cleanup;
   assign rsp_session_locked = out_ff.locked;
   assign rsp_session_mtu    = out_ff.mtu;
   assign rsp_last           = out_ff.last;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("item taken without going busy");
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without result");
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid) else $error("result during clearing");
   a_swept_count: assert property (@(posedge clock) disable iff (reset)
      (swept_ff <= 7'(MAX_SWEEP))) else $error("sweep count overrun");
`endif

endmodule
